@@ rtl/core/dmh_pkg.sv @@
// Shared types and codes for the deadline min-heap.
package dmh_pkg;

  localparam int unsigned HandleW   = 15;
  localparam int unsigned DlOutW    = 48;
  localparam int unsigned CountOutW = 6;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] handle;
    logic [47:0] deadline;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [HandleW-1:0]   popped_handle;
    logic [DlOutW-1:0]    popped_deadline;
    logic [CountOutW-1:0] entry_count;
    logic                 head_valid;
    logic [HandleW-1:0]   head_handle;
    logic [DlOutW-1:0]    head_deadline;
  } rsp_t;

endpackage

@@ rtl/core/dmh_if.sv @@
// Valid/ready channel carrying one payload beat.
interface dmh_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/deadline_min_heap.sv @@
// Deadline min-heap: priority queue of (handle, deadline) entries ordered by deadline.
// The heap lives in one synchronous memory of CAPACITY {handle, deadline} slots with a
// registered read. The moving entry is held in a register while the walk shifts other
// entries through the hole. Each level going up takes a parent read, then a compare and
// write; each level going down takes two child reads, then a compare and write. A
// request beat is taken whenever the sequencer is idle. The response beat has its own
// register, so a stalled response only holds the sequencer in its final state, S_DONE.
// Invalid handle, full, empty and unused codes go straight to the response build.
// Remove scans one slot per cycle before it sifts.
module deadline_min_heap #(
  parameter int unsigned CAPACITY      = 32,
  parameter int unsigned DEADLINE_BITS = 48
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dmh_if.sink   req_i,
  dmh_if.source rsp_o
);
  import dmh_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = DEADLINE_BITS;
  localparam int unsigned EW = HandleW + DW;
  localparam int unsigned XW = AW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_PLACE, S_POP_RD, S_POP_LAST, S_POP_FILL, S_SCAN,
    S_RM_LAST, S_RM_FILL, S_RM_CMP, S_DN_L, S_DN_R, S_DN_CMP, S_HEAD, S_DONE
  } state_e;

  // Slot memory: {handle, deadline}
  logic [EW-1:0] mem_q [CAPACITY];
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd, rd_q;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  state_e             state_q;
  logic [CW-1:0]      cnt_q, idx_q;
  logic [AW-1:0]      pos_q, best_q;
  logic [EW-1:0]      cur_q, bst_q;
  logic [HandleW-1:0] key_q;
  status_e            st_q;
  logic [HandleW-1:0] ph_q;
  logic [DlOutW-1:0]  pd_q;
  rsp_t               rsp_q;
  logic               rsp_v_q;

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = rsp_v_q;
  assign rsp_o.payload = rsp_q;

  function automatic logic [DW-1:0] dl_of(logic [EW-1:0] e);
    return e[DW-1:0];
  endfunction

  function automatic logic [DlOutW-1:0] dl_out(logic [EW-1:0] e);
    logic [63:0] w;
    w = 64'(e[DW-1:0]);
    return w[DlOutW-1:0];
  endfunction

  // Tree neighbors of the hole and the down-walk decision
  logic [AW-1:0] parent;
  logic [XW-1:0] child_l, child_r, cnt_x;
  logic          up_less, take_r, dn_move, rd_hit;
  logic [EW-1:0] dn_ent;
  logic [AW-1:0] dn_pos;

  assign parent  = AW'((pos_q - AW'(1)) >> 1);
  assign child_l = {1'b0, pos_q, 1'b1};
  assign child_r = child_l + XW'(1);
  assign cnt_x   = XW'(cnt_q);
  assign up_less = dl_of(cur_q) < dl_of(rd_q);
  assign take_r  = (child_r < cnt_x) && (dl_of(rd_q) < dl_of(bst_q));
  assign dn_move = take_r || (best_q != pos_q);
  assign dn_ent  = take_r ? rd_q : bst_q;
  assign dn_pos  = take_r ? child_r[AW-1:0] : best_q;
  assign rd_hit  = (idx_q != '0) && (rd_q[EW-1:DW] == key_q);

  // Memory port drive
  always_comb begin
    we = 1'b0;
    wa = pos_q;
    wd = cur_q;
    ra = '0;
    case (state_q)
      S_UP_RD, S_RM_FILL: ra = parent;
      S_UP_CMP, S_RM_CMP: begin
        if (up_less) begin
          we = 1'b1;
          wd = rd_q;
        end
      end
      S_PLACE: we = 1'b1;
      S_POP_LAST, S_RM_LAST: ra = AW'(cnt_q);
      S_SCAN: ra = AW'(idx_q);
      S_DN_L: ra = child_l[AW-1:0];
      S_DN_R: ra = child_r[AW-1:0];
      S_DN_CMP: begin
        if (dn_move) begin
          we = 1'b1;
          wd = dn_ent;
        end
      end
      default: ;
    endcase
  end

  logic [DW-1:0]  in_dl;
  logic [63:0]    in_dl_w;
  assign in_dl_w = 64'(req_i.payload.deadline);
  assign in_dl   = in_dl_w[DW-1:0];

  // Sequencer: request decode, sift walks, scan and response build
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      best_q  <= '0;
      cur_q   <= '0;
      bst_q   <= '0;
      key_q   <= '0;
      st_q    <= ST_OK;
      ph_q    <= '0;
      pd_q    <= '0;
      rsp_q   <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      // Offer the response beat once built, drop it when taken
      if (state_q == S_DONE && (!rsp_v_q || rsp_o.ready)) rsp_v_q <= 1'b1;
      else if (rsp_o.ready) rsp_v_q <= 1'b0;

      case (state_q)
        S_IDLE: if (req_i.valid) begin
          key_q <= req_i.payload.handle[HandleW-1:0];
          ph_q  <= '0;
          pd_q  <= '0;
          case (req_i.payload.req_type)
            REQ_ADD: begin
              if (req_i.payload.handle[15]) begin
                st_q    <= ST_INVALID;
                state_q <= S_HEAD;
              end else if (cnt_q >= CW'(CAPACITY)) begin
                st_q    <= ST_FULL;
                state_q <= S_HEAD;
              end else begin
                st_q    <= ST_OK;
                pos_q   <= AW'(cnt_q);
                cur_q   <= {req_i.payload.handle[HandleW-1:0], in_dl};
                cnt_q   <= cnt_q + CW'(1);
                state_q <= S_UP_RD;
              end
            end
            REQ_POP: begin
              if (cnt_q == '0) begin
                st_q    <= ST_EMPTY;
                state_q <= S_HEAD;
              end else begin
                st_q    <= ST_OK;
                cnt_q   <= cnt_q - CW'(1);
                state_q <= S_POP_RD;
              end
            end
            REQ_REMOVE: begin
              if (req_i.payload.handle[15]) begin
                st_q    <= ST_INVALID;
                state_q <= S_HEAD;
              end else if (cnt_q == '0) begin
                st_q    <= ST_NOT_FOUND;
                state_q <= S_HEAD;
              end else begin
                st_q    <= ST_OK;
                idx_q   <= '0;
                state_q <= S_SCAN;
              end
            end
            default: begin
              st_q    <= ST_OK;
              state_q <= S_HEAD;
            end
          endcase
        end
        S_UP_RD: state_q <= (pos_q == '0) ? S_PLACE : S_UP_CMP;
        S_UP_CMP: begin
          // move the parent down into the hole while the walking entry is smaller
          if (up_less) begin
            pos_q   <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: state_q <= S_HEAD;
        S_POP_RD: state_q <= S_POP_LAST;
        S_POP_LAST: begin
          ph_q    <= rd_q[EW-1:DW];
          pd_q    <= dl_out(rd_q);
          state_q <= S_POP_FILL;
        end
        S_POP_FILL: begin
          // last entry walks down from the root
          cur_q   <= rd_q;
          pos_q   <= '0;
          state_q <= (cnt_q == '0) ? S_HEAD : S_DN_L;
        end
        S_SCAN: begin
          // advance one slot per cycle; read data is for idx_q-1
          if (rd_hit) begin
            pos_q   <= AW'(idx_q - CW'(1));
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_RM_LAST;
          end else if (idx_q == cnt_q) begin
            st_q    <= ST_NOT_FOUND;
            state_q <= S_HEAD;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_RM_LAST: state_q <= S_RM_FILL;
        S_RM_FILL: begin
          // last entry now fills the hole
          cur_q <= rd_q;
          if (CW'(pos_q) >= cnt_q) state_q <= S_HEAD;
          else if (pos_q == '0) state_q <= S_DN_L;
          else state_q <= S_RM_CMP;
        end
        S_RM_CMP: begin
          if (up_less) begin
            pos_q   <= parent;
            state_q <= S_UP_RD;
          end else begin
            state_q <= S_DN_L;
          end
        end
        S_DN_L: begin
          bst_q   <= cur_q;
          best_q  <= pos_q;
          state_q <= (child_l < cnt_x) ? S_DN_R : S_PLACE;
        end
        S_DN_R: begin
          if (dl_of(rd_q) < dl_of(bst_q)) begin
            bst_q  <= rd_q;
            best_q <= child_l[AW-1:0];
          end
          state_q <= S_DN_CMP;
        end
        S_DN_CMP: begin
          // pull the smaller child up into the hole, or stop
          if (dn_move) begin
            pos_q   <= dn_pos;
            state_q <= S_DN_L;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_HEAD: state_q <= S_DONE;
        S_DONE: begin
          if (!rsp_v_q || rsp_o.ready) begin
            rsp_q <= '{status:          st_q,
                       popped_handle:   ph_q,
                       popped_deadline: pd_q,
                       entry_count:     CountOutW'(cnt_q),
                       head_valid:      (cnt_q != '0),
                       head_handle:     (cnt_q != '0) ? rd_q[EW-1:DW] : '0,
                       head_deadline:   (cnt_q != '0) ? dl_out(rd_q) : '0};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we)
    else $error("memory written while idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_v_q && !rsp_o.ready |=> rsp_v_q && $stable(rsp_q))
    else $error("response dropped while stalled");
endmodule
